### rtl/iasm_pkg.sv
// ----------------------------------------------------------------------------
// iasm_pkg
// Shared types and constants of the integer add/subtract/multiply unit.
// ----------------------------------------------------------------------------
package iasm_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned HalfW = 16;
  localparam int unsigned OpW   = 3;

  // Operation codes; codes 6 and 7 are undefined and yield all-zero results
  typedef enum logic [OpW-1:0] {
    OP_UADD  = 3'd0,
    OP_USUB  = 3'd1,
    OP_SADD  = 3'd2,
    OP_SSUB  = 3'd3,
    OP_UMULT = 3'd4,
    OP_SMULT = 3'd5
  } opcode_e;

  // Add/subtract unit outputs for one request
  typedef struct packed {
    logic [WordW-1:0] sum;       // wrapped a+b
    logic [WordW-1:0] diff;      // wrapped a-b
    logic             carry;     // unsigned carry out of the add
    logic             borrow;    // unsigned borrow of the subtract
    logic             add_ovf;   // signed overflow of the add
    logic             sub_ovf;   // signed overflow of the subtract
  } addsub_res_t;

endpackage

### rtl/iasm_addsub.sv
// ----------------------------------------------------------------------------
// iasm_addsub
// Combinational 32-bit adder and subtractor with carry, borrow and signed
// overflow detection.
// ----------------------------------------------------------------------------
module iasm_addsub
  import iasm_pkg::*;
(
  input  logic [WordW-1:0] a_i,
  input  logic [WordW-1:0] b_i,
  output addsub_res_t      res_o
);

  logic [WordW:0] sum_ext;
  logic [WordW:0] diff_ext;

  // Extended add and subtract; the top bit is carry or borrow
  assign sum_ext  = {1'b0, a_i} + {1'b0, b_i};
  assign diff_ext = {1'b0, a_i} - {1'b0, b_i};

  assign res_o.sum    = sum_ext[WordW-1:0];
  assign res_o.diff   = diff_ext[WordW-1:0];
  assign res_o.carry  = sum_ext[WordW];
  assign res_o.borrow = diff_ext[WordW];

  // Signed overflow by sign rule
  assign res_o.add_ovf = ~(a_i[WordW-1] ^ b_i[WordW-1]) &
                         (a_i[WordW-1] ^ sum_ext[WordW-1]);
  assign res_o.sub_ovf = (a_i[WordW-1] ^ b_i[WordW-1]) &
                         (a_i[WordW-1] ^ diff_ext[WordW-1]);

endmodule

### rtl/iasm_mul_pipe.sv
// ----------------------------------------------------------------------------
// iasm_mul_pipe
// Three-stage 32x32 multiplier: 16x16 partial products, partial-product sum,
// then the two's complement correction of the high word.
// ----------------------------------------------------------------------------
module iasm_mul_pipe
  import iasm_pkg::*;
(
  input  logic               clk_i,
  input  logic [WordW-1:0]   a_i,
  input  logic [WordW-1:0]   b_i,
  input  logic               signed_i,
  output logic [2*WordW-1:0] prod_o
);

  // Stage 1: partial products and correction inputs
  logic [WordW-1:0] pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  logic [WordW-1:0] corr_a_q, corr_b_q;
  // Stage 2: unsigned product and combined correction
  logic [2*WordW-1:0] uprod_q;
  logic [WordW-1:0]   corr_q;
  // Stage 3: corrected product
  logic [2*WordW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    pp_ll_q  <= a_i[HalfW-1:0]     * b_i[HalfW-1:0];
    pp_lh_q  <= a_i[HalfW-1:0]     * b_i[WordW-1:HalfW];
    pp_hl_q  <= a_i[WordW-1:HalfW] * b_i[HalfW-1:0];
    pp_hh_q  <= a_i[WordW-1:HalfW] * b_i[WordW-1:HalfW];
    // a negative subtracts b from the high word, b negative subtracts a
    corr_a_q <= (signed_i && a_i[WordW-1]) ? b_i : '0;
    corr_b_q <= (signed_i && b_i[WordW-1]) ? a_i : '0;
  end

  always_ff @(posedge clk_i) begin
    uprod_q <= {pp_hh_q, pp_ll_q}
             + {{HalfW{1'b0}}, pp_lh_q, {HalfW{1'b0}}}
             + {{HalfW{1'b0}}, pp_hl_q, {HalfW{1'b0}}};
    corr_q  <= corr_a_q + corr_b_q;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= {uprod_q[2*WordW-1:WordW] - corr_q, uprod_q[WordW-1:0]};
  end

  assign prod_o = prod_q;

endmodule

### rtl/integer_add_sub_mult_unit.sv
// ----------------------------------------------------------------------------
// integer_add_sub_mult_unit
// Integer add, subtract and exact 32x32 multiply unit with a fixed latency.
// ----------------------------------------------------------------------------
// Usage: the unit takes a request at every clock edge where start_i is high;
// busy_o is always low, so a request may be issued in every cycle. Each
// request yields exactly one result, shown on the result ports for one cycle
// with done_o high; the receiver cannot stall the unit and must take the
// result in that cycle. The result passes the three-stage multiplier
// (partial products, partial-product sum, signed correction) and then the
// result select register; add and subtract results ride along the same
// stages so order is kept.
module integer_add_sub_mult_unit
  import iasm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [OpW-1:0]   opcode_i,
  input  logic [WordW-1:0] operand_a_i,
  input  logic [WordW-1:0] operand_b_i,
  output logic             done_o,
  output logic [WordW-1:0] result_low_o,
  output logic [WordW-1:0] result_high_o,
  output logic             overflow_flag_o
);

  localparam int unsigned Stages = 4;

  addsub_res_t        as_res;
  logic [2*WordW-1:0] prod;
  logic               req;

  // Valid bits and stage payload
  logic [Stages-1:0]  vld_q;
  logic [OpW-1:0]     op_q [Stages-1];
  logic [WordW-1:0]   as_low_q [Stages-1];
  logic               as_flag_q [Stages-1];
  logic [WordW-1:0]   as_low_d;
  logic               as_flag_d;

  logic [WordW-1:0]   res_low_d, res_high_d;
  logic               res_flag_d;
  logic [WordW-1:0]   res_low_q, res_high_q;
  logic               res_flag_q;

  assign busy_o = 1'b0;
  assign req    = start_i && !busy_o;

  iasm_addsub u_addsub (
    .a_i   (operand_a_i),
    .b_i   (operand_b_i),
    .res_o (as_res)
  );

  iasm_mul_pipe u_mul (
    .clk_i    (clk_i),
    .a_i      (operand_a_i),
    .b_i      (operand_b_i),
    .signed_i (opcode_i == OP_SMULT),
    .prod_o   (prod)
  );

  // Select add/sub word and flag in the first stage
  always_comb begin
    as_low_d  = '0;
    as_flag_d = 1'b0;
    case (opcode_i)
      OP_UADD: begin
        as_low_d  = as_res.sum;
        as_flag_d = as_res.carry;
      end
      OP_USUB: begin
        as_low_d  = as_res.diff;
        as_flag_d = as_res.borrow;
      end
      OP_SADD: begin
        as_low_d  = as_res.sum;
        as_flag_d = as_res.add_ovf;
      end
      OP_SSUB: begin
        as_low_d  = as_res.diff;
        as_flag_d = as_res.sub_ovf;
      end
      default: begin
        as_low_d  = '0;
        as_flag_d = 1'b0;
      end
    endcase
  end

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Stages-2:0], req};
    end
  end

  // Payload alongside the multiplier stages
  always_ff @(posedge clk_i) begin
    op_q[0]      <= opcode_i;
    as_low_q[0]  <= as_low_d;
    as_flag_q[0] <= as_flag_d;
    for (int i = 1; i < Stages - 1; i++) begin
      op_q[i]      <= op_q[i-1];
      as_low_q[i]  <= as_low_q[i-1];
      as_flag_q[i] <= as_flag_q[i-1];
    end
  end

  // Final result select
  always_comb begin
    res_low_d  = '0;
    res_high_d = '0;
    res_flag_d = 1'b0;
    case (op_q[Stages-2])
      OP_UADD, OP_USUB, OP_SADD, OP_SSUB: begin
        res_low_d  = as_low_q[Stages-2];
        res_flag_d = as_flag_q[Stages-2];
      end
      OP_UMULT, OP_SMULT: begin
        res_low_d  = prod[WordW-1:0];
        res_high_d = prod[2*WordW-1:WordW];
      end
      default: begin
        res_low_d  = '0;
        res_high_d = '0;
        res_flag_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_low_q  <= res_low_d;
    res_high_q <= res_high_d;
    res_flag_q <= res_flag_d;
  end

  assign done_o          = vld_q[Stages-1];
  assign result_low_o    = res_low_q;
  assign result_high_o   = res_high_q;
  assign overflow_flag_o = res_flag_q;

  // Each result traces back to an earlier request
  a_done_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Stages))
    else $error("result without matching request");

  // Add and subtract leave the high word clear
  a_addsub_high_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(opcode_i, Stages) == OP_UADD || $past(opcode_i, Stages) == OP_USUB ||
      $past(opcode_i, Stages) == OP_SADD || $past(opcode_i, Stages) == OP_SSUB))
    |-> (result_high_o == '0))
    else $error("add/sub result has nonzero high word");

  // Multiplies never flag
  a_mult_no_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(opcode_i, Stages) == OP_UMULT ||
      $past(opcode_i, Stages) == OP_SMULT)) |-> !overflow_flag_o)
    else $error("multiply raised overflow flag");

  // Unsigned multiply low word matches the operands' low product
  a_umult_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(opcode_i, Stages) == OP_UMULT) |->
    (result_low_o == WordW'($past(operand_a_i, Stages) * $past(operand_b_i, Stages))))
    else $error("multiply low word mismatch");

endmodule

### tb/sv/integer_add_sub_mult_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_add_sub_mult_unit_tb
// Self-checking bench for the add/subtract/multiply unit. A queue of requests
// (directed corner cases, then constrained-by-hand random ones) feeds a
// clocked driver with random gaps. A clocked monitor predicts the result of
// every accepted request and compares each done_o strobe against the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module integer_add_sub_mult_unit_tb
  import iasm_pkg::*;
();

  localparam int unsigned NumRandomReqs = 1250;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned TailCycles    = 10;
  localparam int unsigned MaxPrinted    = 50;

  // Codes the package leaves undefined; the unit must answer with zeros
  localparam logic [OpW-1:0] OpUndefLo = 3'd6;
  localparam logic [OpW-1:0] OpUndefHi = 3'd7;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic             drain_first;  // hold off until all results are back
  } arith_req_t;

  typedef struct packed {
    logic [WordW-1:0] lo;
    logic [WordW-1:0] hi;
    logic             ovf;
  } arith_res_t;

  typedef struct packed {
    arith_req_t req;
    arith_res_t res;
  } arith_expect_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start_i     = 1'b0;
  logic [OpW-1:0]   opcode_i    = '0;
  logic [WordW-1:0] operand_a_i = '0;
  logic [WordW-1:0] operand_b_i = '0;
  logic             busy_o;
  logic             done_o;
  logic [WordW-1:0] result_low_o;
  logic [WordW-1:0] result_high_o;
  logic             overflow_flag_o;

  arith_req_t    pending_reqs[$];
  arith_expect_t expected_results[$];

  int unsigned n_issued;
  int unsigned n_completed = 0;
  int unsigned n_errors    = 0;
  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned gap_roll;
  int unsigned idle_cycles = 0;
  logic        req_taken;
  arith_req_t  next_req;
  arith_req_t  seen_req;
  arith_expect_t got_expect;

  integer_add_sub_mult_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .operand_a_i    (operand_a_i),
    .operand_b_i    (operand_b_i),
    .done_o         (done_o),
    .result_low_o   (result_low_o),
    .result_high_o  (result_high_o),
    .overflow_flag_o(overflow_flag_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Expected result of one request
  function automatic arith_res_t predict_arith(arith_req_t r);
    arith_res_t       res;
    logic [WordW:0]   wide;
    logic [2*WordW-1:0] prod;
    res  = '0;
    wide = '0;
    prod = '0;
    case (r.opcode)
      OP_UADD: begin
        wide    = {1'b0, r.a} + {1'b0, r.b};
        res.lo  = wide[WordW-1:0];
        res.ovf = wide[WordW];
      end
      OP_USUB: begin
        res.lo  = r.a - r.b;
        res.ovf = (r.a < r.b);
      end
      OP_SADD: begin
        res.lo  = r.a + r.b;
        res.ovf = (r.a[WordW-1] == r.b[WordW-1]) && (res.lo[WordW-1] != r.a[WordW-1]);
      end
      OP_SSUB: begin
        res.lo  = r.a - r.b;
        res.ovf = (r.a[WordW-1] != r.b[WordW-1]) && (res.lo[WordW-1] != r.a[WordW-1]);
      end
      OP_UMULT: begin
        prod   = {{WordW{1'b0}}, r.a} * {{WordW{1'b0}}, r.b};
        res.lo = prod[WordW-1:0];
        res.hi = prod[2*WordW-1:WordW];
      end
      OP_SMULT: begin
        // sign-extend to 64 bits; the low 64 bits of the product are exact
        prod   = {{WordW{r.a[WordW-1]}}, r.a} * {{WordW{r.b[WordW-1]}}, r.b};
        res.lo = prod[WordW-1:0];
        res.hi = prod[2*WordW-1:WordW];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [WordW-1:0] pick_operand();
    logic [WordW-1:0] corners[5];
    corners = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
                32'hFFFF_FFFF};
    case ($urandom_range(0, 9))
      0: return corners[$urandom_range(0, 4)];
      1: return $urandom_range(0, 15);
      2: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
      3: return 32'h8000_0000 ^ $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  task automatic add_req(logic [OpW-1:0] op, logic [WordW-1:0] a, logic [WordW-1:0] b,
                         logic drain_first = 1'b0);
    pending_reqs.push_back('{opcode: op, a: a, b: b, drain_first: drain_first});
  endtask

  task automatic report_mismatch(string field, logic [WordW-1:0] got,
                                 logic [WordW-1:0] want, arith_req_t r);
    n_errors++;
    if (n_errors <= MaxPrinted) begin
      $display("%0t: %s mismatch: got %h want %h (op %0d a %h b %h)",
               $realtime, field, got, want, r.opcode, r.a, r.b);
    end
  endtask

  // Driver: one request from the queue at a time, random gaps in between
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i     <= 1'b0;
      opcode_i    <= '0;
      operand_a_i <= '0;
      operand_b_i <= '0;
      n_issued    = 0;
      gap_left    = 0;
      burst_left  = 0;
    end else begin
      req_taken = start_i && !busy_o;
      if (req_taken) n_issued++;
      if (start_i && !req_taken) begin
        // request not taken yet: hold it
      end else if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (pending_reqs.size() > 0 &&
                   !(pending_reqs[0].drain_first && n_issued != n_completed)) begin
        next_req = pending_reqs.pop_front();
        start_i     <= 1'b1;
        opcode_i    <= next_req.opcode;
        operand_a_i <= next_req.a;
        operand_b_i <= next_req.b;
        // mostly back-to-back or short gaps, some long ones, some gapless bursts
        if (burst_left > 0) begin
          burst_left--;
          gap_left = 0;
        end else begin
          gap_roll = $urandom_range(0, 99);
          if (gap_roll < 4) begin
            burst_left = $urandom_range(20, 80);
            gap_left   = 0;
          end else if (gap_roll < 55) begin
            gap_left = 0;
          end else if (gap_roll < 92) begin
            gap_left = $urandom_range(1, 3);
          end else begin
            gap_left = $urandom_range(8, 30);
          end
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: check results, then record the request taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        n_completed <= n_completed + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", result_low_o, '0, '0);
        end else begin
          got_expect = expected_results.pop_front();
          if (result_low_o !== got_expect.res.lo)
            report_mismatch("result_low", result_low_o, got_expect.res.lo, got_expect.req);
          if (result_high_o !== got_expect.res.hi)
            report_mismatch("result_high", result_high_o, got_expect.res.hi, got_expect.req);
          if (overflow_flag_o !== got_expect.res.ovf)
            report_mismatch("overflow_flag", {31'b0, overflow_flag_o},
                            {31'b0, got_expect.res.ovf}, got_expect.req);
        end
      end
      if (start_i && !busy_o) begin
        seen_req = '{opcode: opcode_i, a: operand_a_i, b: operand_b_i, drain_first: 1'b0};
        expected_results.push_back('{req: seen_req, res: predict_arith(seen_req)});
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("integer_add_sub_mult_unit_tb NOT OK");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    // carry, borrow and wrap at the edges of the word
    add_req(OP_UADD, 32'h0000_0000, 32'h0000_0000);
    add_req(OP_UADD, 32'hFFFF_FFFF, 32'h0000_0001);
    add_req(OP_UADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(OP_USUB, 32'h0000_0000, 32'h0000_0001);
    add_req(OP_USUB, 32'h0000_0005, 32'h0000_0005);
    add_req(OP_USUB, 32'hFFFF_FFFF, 32'h0000_0000);
    // signed overflow on both sides, and a wrap that is not an overflow
    add_req(OP_SADD, 32'h7FFF_FFFF, 32'h0000_0001);
    add_req(OP_SADD, 32'h8000_0000, 32'h8000_0000);
    add_req(OP_SADD, 32'hFFFF_FFFF, 32'h0000_0001);
    add_req(OP_SSUB, 32'h8000_0000, 32'h0000_0001);
    add_req(OP_SSUB, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_req(OP_SSUB, 32'h0000_0000, 32'h8000_0000);
    add_req(OP_SSUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // unsigned products with carries out of the middle partial sum
    add_req(OP_UMULT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(OP_UMULT, 32'h0000_0000, 32'hFFFF_FFFF);
    add_req(OP_UMULT, 32'hFFFF_0001, 32'h0001_FFFF);
    // signed products around the most negative value
    add_req(OP_SMULT, 32'h8000_0000, 32'h8000_0000);
    add_req(OP_SMULT, 32'h8000_0000, 32'hFFFF_FFFF);
    add_req(OP_SMULT, 32'h7FFF_FFFF, 32'h8000_0000);
    add_req(OP_SMULT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(OP_SMULT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // undefined codes give all-zero results
    add_req(OpUndefLo, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(OpUndefHi, 32'hFFFF_FFFF, 32'h8000_0000);

    for (int i = 0; i < NumRandomReqs; i++) begin
      logic [OpW-1:0] op;
      case ($urandom_range(0, 39))
        0:       op = OpUndefLo;
        1:       op = OpUndefHi;
        default: op = OpW'($urandom_range(OP_UADD, OP_SMULT));
      endcase
      add_req(op, pick_operand(), pick_operand(), (i % 400) == 0);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // all requests issued and every result back
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || start_i || expected_results.size() != 0);
    repeat (TailCycles) @(negedge clk_i);

    if (n_errors == 0) begin
      $display("integer_add_sub_mult_unit_tb OK");
    end else begin
      $display("integer_add_sub_mult_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
